### design/tss_pkg.sv
// shared types, codes and constants of the tcp send segmenter
package tss_pkg;

  // request operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_SEND  = 2'd1;
  localparam logic [1:0] OP_RETX  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_SEGMENT = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_CLOSED  = 3'd2;
  localparam logic [2:0] ST_SHORT   = 3'd3;
  localparam logic [2:0] ST_STARTED = 3'd4;

  // segment size register reset value and floor, window ceiling
  localparam logic [15:0] MSS_RESET = 16'd1460;
  localparam logic [15:0] MSS_FLOOR = 16'd1024;
  localparam logic [15:0] WIN_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] ack_point;
    logic [15:0] send_window;
    logic [31:0] buffered_bytes;
    logic        limit_enable;
    logic [15:0] limit_bytes;
    logic        full_only;
    logic        fin_pending;
    logic [31:0] fin_sequence;
    logic [31:0] start_sequence;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] segment_sequence;
    logic [15:0] segment_length;
    logic        fin_flag;
    logic        last;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic calc;
    logic decide;
    logic emit;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic op_none;
    logic out_free;
    logic emit_last;
  } dp_stat_t;

endpackage

### design/tss_in_if.sv
// request channel interface of the tcp send segmenter
interface tss_in_if import tss_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/tss_out_if.sv
// result channel interface of the tcp send segmenter
interface tss_out_if import tss_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/tss_datapath.sv
// sequence state, window arithmetic and result register of the segmenter
module tss_datapath import tss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  in_item_t  in_data,
  input  ctl_cmd_t  cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // sequence state and segment size register
  logic [15:0] mss_r;
  logic [31:0] next_r, next_nxt;
  logic [31:0] hs_r, hs_nxt;

  // captured request
  logic [1:0]  op_r;
  logic [31:0] ack_r;
  logic [15:0] wnd_r;
  logic [31:0] buf_r;
  logic        lim_en_r;
  logic [15:0] lim_r;
  logic        full_only_r;
  logic        fin_pend_r;
  logic [31:0] fin_seq_r;
  logic [31:0] start_r;

  // working registers
  logic [31:0] diff_r, diff_nxt;
  logic [15:0] win_r, win_nxt;
  logic [2:0]  status_r, status_nxt;

  // result register
  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  logic [15:0] mss_eff;
  logic [15:0] win_a, win_b, win_c;
  logic [2:0]  send_status;
  logic        retx_bad;
  logic [15:0] retx_len;
  logic [31:0] start_seq1;
  logic [15:0] seg_len, win_rem;
  logic [31:0] seg_end, seq_after;
  logic        fin_hit, is_seg, out_free;

  // effective segment size, never below the floor
  assign mss_eff = (mss_r < MSS_FLOOR) ? MSS_FLOOR : mss_r;

  // raw window for send, outstanding bytes for retransmit
  assign diff_nxt = (op_r == OP_SEND) ? (ack_r + {16'd0, wnd_r} - hs_r) : (hs_r - ack_r);

  // clip window: behind send point, ceiling, byte limit, buffered bytes
  always_comb begin
    win_a = diff_r[31] ? 16'd0 : ((|diff_r[30:16]) ? WIN_MAX : diff_r[15:0]);
    win_b = (lim_en_r && (lim_r < win_a)) ? lim_r : win_a;
    win_c = ((buf_r[31:16] == 16'd0) && (buf_r[15:0] < win_b)) ? buf_r[15:0] : win_b;
    if (buf_r == 32'd0) begin
      send_status = ST_EMPTY;
    end else if (win_c == 16'd0) begin
      send_status = ST_CLOSED;
    end else if (full_only_r && (win_c < mss_eff)) begin
      send_status = ST_SHORT;
    end else begin
      send_status = ST_SEGMENT;
    end
  end

  // retransmit length and nothing-outstanding check
  assign retx_bad   = (diff_r == 32'd0) || diff_r[31];
  assign retx_len   = ((|diff_r[30:16]) || (diff_r[15:0] >= mss_eff)) ? mss_eff : diff_r[15:0];
  assign start_seq1 = start_r + 32'd1;

  // current segment and fin placement
  assign seg_len   = (win_r < mss_eff) ? win_r : mss_eff;
  assign win_rem   = win_r - seg_len;
  assign seg_end   = next_r + {16'd0, seg_len};
  assign fin_hit   = fin_pend_r && (seg_end == fin_seq_r);
  assign seq_after = fin_hit ? (fin_seq_r + 32'd1) : seg_end;
  assign is_seg    = (status_r == ST_SEGMENT);
  assign out_free  = !out_valid_r || out_ready;

  // next values of the sequence state and working registers
  always_comb begin
    next_nxt   = next_r;
    hs_nxt     = hs_r;
    win_nxt    = win_r;
    status_nxt = status_r;
    if (cmd.decide) begin
      case (op_r)
        OP_START: begin
          status_nxt = ST_STARTED;
          win_nxt    = 16'd0;
          next_nxt   = start_seq1;
          hs_nxt     = start_seq1;
        end
        OP_SEND: begin
          status_nxt = send_status;
          win_nxt    = win_c;
          next_nxt   = hs_r;
        end
        OP_RETX: begin
          status_nxt = retx_bad ? ST_EMPTY : ST_SEGMENT;
          win_nxt    = retx_len;
          next_nxt   = ack_r;
        end
        default: begin
          status_nxt = status_r;
        end
      endcase
    end else if (cmd.emit && is_seg) begin
      win_nxt  = win_rem;
      next_nxt = seq_after;
      if ((win_rem == 16'd0) && (op_r == OP_SEND)) begin
        hs_nxt = seq_after;
      end
    end
  end

  // result item to load
  always_comb begin
    if (is_seg) begin
      out_data_nxt.status           = ST_SEGMENT;
      out_data_nxt.segment_sequence = next_r;
      out_data_nxt.segment_length   = seg_len;
      out_data_nxt.fin_flag         = fin_hit;
      out_data_nxt.last             = (win_rem == 16'd0);
    end else begin
      out_data_nxt.status           = status_r;
      out_data_nxt.segment_sequence = next_r;
      out_data_nxt.segment_length   = 16'd0;
      out_data_nxt.fin_flag         = 1'b0;
      out_data_nxt.last             = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mss_r       <= MSS_RESET;
      next_r      <= 32'd0;
      hs_r        <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mss_r <= cfg_wr_data;
      end
      next_r <= next_nxt;
      hs_r   <= hs_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= in_data.operation;
      ack_r       <= in_data.ack_point;
      wnd_r       <= in_data.send_window;
      buf_r       <= in_data.buffered_bytes;
      lim_en_r    <= in_data.limit_enable;
      lim_r       <= in_data.limit_bytes;
      full_only_r <= in_data.full_only;
      fin_pend_r  <= in_data.fin_pending;
      fin_seq_r   <= in_data.fin_sequence;
      start_r     <= in_data.start_sequence;
    end
    if (cmd.calc) begin
      diff_r <= diff_nxt;
    end
    win_r    <= win_nxt;
    status_r <= status_nxt;
    if (cmd.emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign stat.op_none   = (in_data.operation == OP_NONE);
  assign stat.out_free  = out_free;
  assign stat.emit_last = !is_seg || (win_rem == 16'd0);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.emit)
    else $error("result register overwritten while held");

endmodule

### design/tss_controller.sv
// request sequencing state machine of the segmenter
module tss_controller import tss_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CALC   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid && !stat.op_none) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = stat.out_free;
        if (stat.out_free && stat.emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // an accepted request that does real work starts the window step
  a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !stat.op_none) |=> (state_r == S_CALC))
    else $error("accepted request did not start processing");

  // results are loaded only into a free result register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("emit while result register busy");

  // the decision step always leads to emission
  a_decide_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |=> (state_r == S_EMIT))
    else $error("decision step not followed by emission");

endmodule

### design/tcp_send_segmenter_top.sv
// Top level of the tcp send segmenter. Each request is taken while idle, then spends one step
// forming the raw window (or the outstanding byte count) and one step clipping it and choosing
// the outcome; after that one result leaves per cycle while the result channel keeps taking them.
// The block takes no new request until the last result of the current one is loaded into the
// single result register; a request with the no-operation code is dropped with no result.
// The segment size register may be written only while no request is in progress.
module tcp_send_segmenter_top import tss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  tss_in_if.sink      in_chan,
  tss_out_if.source   out_chan
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // state machine
  tss_controller u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic and result register
  tss_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_chan.data),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_data    (out_chan.data)
  );

endmodule
